// ----- hw/rtl/ura_pkg.sv -----
package ura_pkg;

	// Default operand width
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// Base commands
	localparam logic [2:0] CMD_BIN    = 3'd0;
	localparam logic [2:0] CMD_OCT    = 3'd1;
	localparam logic [2:0] CMD_DEC    = 3'd2;
	localparam logic [2:0] CMD_HEX_LO = 3'd3;
	localparam logic [2:0] CMD_HEX_UP = 3'd4;

	// ASCII anchors
	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [3:0] DIGIT_TEN     = 4'd10;

	typedef enum logic [1:0] {
		RADIX_BIN,
		RADIX_OCT,
		RADIX_DEC,
		RADIX_HEX
	} radix_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	// Map one digit (0..15) to its ASCII character
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base_c;
		base_c = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
		if (d < DIGIT_TEN) begin
			digit_char = ASCII_ZERO + {4'b0, d};
		end else begin
			digit_char = base_c + {4'b0, d - DIGIT_TEN};
		end
	endfunction

endpackage

// ----- hw/rtl/ura_if.sv -----
interface ura_in_if
	import ura_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;
	logic [2:0]             command;

	modport source (output valid, value, command, input ready);
	modport sink   (input valid, value, command, output ready);
endinterface

interface ura_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, character, last, input ready);
	modport sink   (input valid, character, last, output ready);
endinterface

// ----- hw/rtl/ura_dabble.sv -----
// One shift-and-correct step of binary to BCD conversion over a row of nibbles
module ura_dabble #(
	parameter int unsigned REG_WIDTH = 48
) (
	input  logic [REG_WIDTH-1:0] bcd,
	input  logic                 bit_in,
	output logic [REG_WIDTH-1:0] bcd_next
);

	localparam int unsigned NIBBLES = REG_WIDTH / 4;

	logic [REG_WIDTH-1:0] fixed;

	// Add three to every digit of five or more, then shift in the next bit
	always_comb begin
		for (int i = 0; i < NIBBLES; i++) begin
			if (bcd[i*4 +: 4] >= 4'd5) begin
				fixed[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
			end else begin
				fixed[i*4 +: 4] = bcd[i*4 +: 4];
			end
		end
	end

	assign bcd_next = {fixed[REG_WIDTH-2:0], bit_in};

endmodule

// ----- hw/rtl/unsigned_radix_to_ascii_unit.sv -----
// Channel  Modport  Payload                                Role
// item     sink     value[VALUE_WIDTH], command[3]         number and base to convert
// result   source   character[8], last                     ASCII digits, MSD first
//
// The transaction is taken while idle; powers-of-two bases then walk a digit register of
// DIG_WIDTH bits (48 at 32-bit values) one digit position per cycle unless the result stalls:
// DIG_WIDTH positions for binary, /3 for octal, /4 for hex. Decimal first runs the
// shift-and-add-3 loop over all VALUE_WIDTH bits of the value, then emits DIG_WIDTH/4 positions.
// Leading zero positions are skipped one by one; a result stall holds the emitting digit.
// arst_n clears the sequencer and the output valid; a new item is taken once the last
// character of the previous one has moved into the output register.
module unsigned_radix_to_ascii_unit
	import ura_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ura_in_if.sink    item,
	ura_out_if.source result
);

	// Decimal digits needed for the largest value, then a digit register wide enough
	// for both the BCD image and the raw value, padded to a multiple of 1, 3 and 4
	localparam int unsigned DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int unsigned RAW_WIDTH  = (VALUE_WIDTH > 4 * DEC_DIGITS) ?
	                                     VALUE_WIDTH : 4 * DEC_DIGITS;
	localparam int unsigned DIG_WIDTH  = ((RAW_WIDTH + 11) / 12) * 12;
	localparam int unsigned CNT_WIDTH  = $clog2(DIG_WIDTH + 1);

	state_t                 state_q, state_d;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic                   started_q;
	logic                   out_valid_q;
	logic [7:0]             out_char_q;
	logic                   out_last_q;
	logic [DIG_WIDTH-1:0]   sr_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	radix_t                 mode_q;
	logic                   upper_q;

	radix_t                 cmd_radix;
	logic                   cmd_upper;
	logic                   accept;
	logic [3:0]             nib;
	logic [3:0]             digit;
	logic                   skip;
	logic                   emit_load;
	logic                   emit_last;
	logic [DIG_WIDTH-1:0]   sr_shift;
	logic [DIG_WIDTH-1:0]   sr_dabble;
	logic [CNT_WIDTH-1:0]   emit_count;

	assign accept     = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);

	// Decode the base; unused codes fall back to decimal
	always_comb begin
		cmd_upper = 1'b0;
		unique case (item.command)
			CMD_BIN:    cmd_radix = RADIX_BIN;
			CMD_OCT:    cmd_radix = RADIX_OCT;
			CMD_HEX_LO: cmd_radix = RADIX_HEX;
			CMD_HEX_UP: begin
				cmd_radix = RADIX_HEX;
				cmd_upper = 1'b1;
			end
			default:    cmd_radix = RADIX_DEC;
		endcase
	end

	// Digit positions in the register for each base
	always_comb begin
		unique case (cmd_radix)
			RADIX_BIN: emit_count = CNT_WIDTH'(DIG_WIDTH);
			RADIX_OCT: emit_count = CNT_WIDTH'(DIG_WIDTH / 3);
			default:   emit_count = CNT_WIDTH'(DIG_WIDTH / 4);
		endcase
	end

	ura_dabble #(
		.REG_WIDTH (DIG_WIDTH)
	) u_dabble (
		.bcd      (sr_q),
		.bit_in   (bin_q[VALUE_WIDTH-1]),
		.bcd_next (sr_dabble)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (cmd_radix == RADIX_DEC) ? ST_CONV : ST_EMIT;
				end
			end
			ST_CONV: begin
				if (cnt_q == CNT_WIDTH'(1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_load && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Emission control: pick the top digit, drop leading zeros, load the output stage
	always_comb begin
		nib = sr_q[DIG_WIDTH-1 -: 4];
		unique case (mode_q)
			RADIX_BIN: begin
				digit    = {3'b0, nib[3]};
				sr_shift = sr_q << 1;
			end
			RADIX_OCT: begin
				digit    = {1'b0, nib[3:1]};
				sr_shift = sr_q << 3;
			end
			default: begin
				digit    = nib;
				sr_shift = sr_q << 4;
			end
		endcase
		emit_last = (cnt_q == CNT_WIDTH'(1));
		skip      = (state_q == ST_EMIT) && (digit == 4'd0) && !started_q && !emit_last;
		emit_load = (state_q == ST_EMIT) && !skip && (!out_valid_q || result.ready);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q     <= (cmd_radix == RADIX_DEC) ?
						             CNT_WIDTH'(VALUE_WIDTH) : emit_count;
						started_q <= 1'b0;
					end
				end
				ST_CONV: begin
					// Switch the counter over to decimal digit positions at the end
					cnt_q <= (cnt_q == CNT_WIDTH'(1)) ?
					         CNT_WIDTH'(DIG_WIDTH / 4) : cnt_q - CNT_WIDTH'(1);
				end
				ST_EMIT: begin
					if (skip || emit_load) begin
						cnt_q <= cnt_q - CNT_WIDTH'(1);
					end
					if (emit_load) begin
						started_q <= 1'b1;
					end
				end
				default: ;
			endcase
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= cmd_radix;
			upper_q <= cmd_upper;
			bin_q   <= item.value;
			sr_q    <= (cmd_radix == RADIX_DEC) ? '0 : DIG_WIDTH'(item.value);
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			sr_q  <= sr_dabble;
		end else if (skip || emit_load) begin
			sr_q <= sr_shift;
		end
		if (emit_load) begin
			out_char_q <= digit_char(digit, upper_q);
			out_last_q <= emit_last;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.character = out_char_q;
	assign result.last      = out_last_q;

	// The position counter never runs dry while converting or emitting
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV || state_q == ST_EMIT) |-> cnt_q != '0)
		else $error("digit counter empty while busy");

	// Loading the final character frees the unit
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && emit_last) |=> state_q == ST_IDLE)
		else $error("unit still busy after final character");

	// An accepted transaction always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted transaction left unit idle");

	// No character reaches the output stage during the BCD loop
	a_conv_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !emit_load)
		else $error("character emitted during conversion");

endmodule

// ----- verif/unsigned_radix_to_ascii_unit_tb.sv -----
`timescale 1ns / 100ps

module unsigned_radix_to_ascii_unit_tb;
	import ura_pkg::*;

	localparam int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF;

	// Commands outside the documented set; the block treats them as decimal
	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd6;
	localparam logic [2:0] CMD_SPARE_C = 3'd7;

	localparam int NUM_DIRECTED   = 24;
	localparam int RANDOM_ITEMS   = 300;
	// Worst quiet stretch: the longest sender gap, the decimal conversion and
	// leading-zero skipping, and the longest receiver stall.
	// Take that several times over, and keep it well above the final drain.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 120;

	// One row of the directed table. An empty string means the expected digits
	// come from the predictor; otherwise the string is the expected output.
	typedef struct {
		logic [VALUE_WIDTH-1:0] value;
		logic [2:0]             command;
		string                  digits;
	} number_row_t;

	// One outgoing character as the block should present it
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} char_beat_t;

	logic clk;
	logic arst_n;

	ura_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) item ();
	ura_out_if result ();

	unsigned_radix_to_ascii_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	// Directed numbers: zero in every base, all ones in every base, the
	// single-bit extremes, the unused commands, and a few mixed patterns.
	number_row_t directed_rows [0:NUM_DIRECTED-1] = '{
		'{32'h0000_0000, CMD_BIN,    "0"},
		'{32'h0000_0000, CMD_OCT,    "0"},
		'{32'h0000_0000, CMD_DEC,    "0"},
		'{32'h0000_0000, CMD_HEX_LO, "0"},
		'{32'h0000_0000, CMD_HEX_UP, "0"},
		'{32'hFFFF_FFFF, CMD_BIN,    "11111111111111111111111111111111"},
		'{32'hFFFF_FFFF, CMD_OCT,    "37777777777"},
		'{32'hFFFF_FFFF, CMD_DEC,    "4294967295"},
		'{32'hFFFF_FFFF, CMD_HEX_LO, "ffffffff"},
		'{32'hFFFF_FFFF, CMD_HEX_UP, "FFFFFFFF"},
		'{32'h0000_0001, CMD_BIN,    "1"},
		'{32'h8000_0000, CMD_BIN,    "10000000000000000000000000000000"},
		'{32'd12345,     CMD_SPARE_A, "12345"},
		'{32'h0000_0000, CMD_SPARE_B, "0"},
		'{32'hFFFF_FFFF, CMD_SPARE_C, "4294967295"},
		'{32'hDEAD_BEEF, CMD_HEX_LO, ""},
		'{32'hDEAD_BEEF, CMD_HEX_UP, ""},
		'{32'h0ABC_DEF0, CMD_HEX_UP, ""},
		'{32'd8,         CMD_OCT,    ""},
		'{32'd1000000000, CMD_DEC,   ""},
		'{32'd9,         CMD_DEC,    ""},
		'{32'd10,        CMD_DEC,    ""},
		'{32'h5555_5555, CMD_BIN,    ""},
		'{32'hAAAA_AAAA, CMD_OCT,    ""}
	};

	logic [2:0] command_pool [0:7] = '{
		CMD_BIN, CMD_OCT, CMD_DEC, CMD_HEX_LO, CMD_HEX_UP,
		CMD_SPARE_A, CMD_SPARE_B, CMD_SPARE_C
	};

	// Characters still owed by the block, oldest first
	char_beat_t awaited_chars [$];

	// Directed row behind the number on the item channel, or -1 for random
	int          item_row;
	int          failures;
	int          items_taken;
	int          chars_seen;
	int          zero_items;
	int          spare_cmd_items;
	int          quiet_cycles;
	int          stall_left;
	logic [31:0] cycle_count;
	string       item_digits;
	char_beat_t  want;

	// Half period of 2 ns
	always #2 clk = ~clk;

	// Spell out a number in the chosen base, most significant digit first,
	// with no leading zeros. Unused commands fall back to decimal.
	function automatic string radix_digits(input logic [VALUE_WIDTH-1:0] value,
			input logic [2:0] command);
		logic [VALUE_WIDTH-1:0] rest;
		int unsigned            base;
		bit                     upper;
		int unsigned            digit;
		logic [7:0]             ch;
		string                  one;
		string                  text;
		rest  = value;
		upper = 1'b0;
		case (command)
			CMD_BIN:    base = 2;
			CMD_OCT:    base = 8;
			CMD_HEX_LO: base = 16;
			CMD_HEX_UP: begin
				base  = 16;
				upper = 1'b1;
			end
			default:    base = 10;
		endcase
		if (rest == '0)
			return "0";
		text = "";
		one  = " ";
		while (rest != '0) begin
			digit = rest % base;
			if (digit < 10)
				ch = ASCII_ZERO + digit[7:0];
			else
				ch = (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + digit[7:0] - 8'd10;
			one.putc(0, ch);
			text = {one, text};
			rest = rest / base;
		end
		return text;
	endfunction

	// Mostly back to back, often a short pause, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Spread values over all digit counts, not only the long ones that plain
	// random words give, and hit the power-of-two boundaries where digits roll over.
	function automatic logic [VALUE_WIDTH-1:0] random_value();
		int unsigned bits;
		bits = $urandom_range(1, VALUE_WIDTH);
		case ($urandom_range(0, 4))
			0, 1: return $urandom;
			2:    return $urandom >> (VALUE_WIDTH - bits);
			3:    return $urandom_range(0, 20);
			default: begin
				if ($urandom_range(0, 1) == 0)
					return ({{(VALUE_WIDTH-1){1'b0}}, 1'b1} << (bits - 1));
				else
					return ({VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - bits));
			end
		endcase
	endfunction

	// Favour the five real bases, with the occasional unused command
	function automatic logic [2:0] random_command();
		if ($urandom_range(0, 9) < 8)
			return command_pool[$urandom_range(0, 4)];
		else
			return command_pool[$urandom_range(5, 7)];
	endfunction

	// Offer one number on the item channel and hold it until it is taken.
	// Call at a rising edge; returns at the edge where the transaction happens.
	task automatic send_number(input logic [VALUE_WIDTH-1:0] value,
			input logic [2:0] command, input int row, input bit calm);
		int gap;
		gap = calm ? 0 : idle_gap();
		if (gap != 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid   <= 1'b1;
		item.value   <= value;
		item.command <= command;
		item_row     <= row;
		do
			@(posedge clk);
		while (!item.ready);
	endtask

	// Stop offering numbers until every owed character has come out.
	// Check at the falling edge so that this edge's transactions are settled.
	task automatic wait_for_drain();
		item.valid <= 1'b0;
		@(negedge clk);
		while (awaited_chars.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Receiver: ready most of the time, with random stalls of mixed length.
	// One stretch in every four is left without stalls.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (stall_left != 0) begin
			result.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			result.ready <= 1'b1;
			if (cycle_count[9:8] != 2'b11 && $urandom_range(0, 3) == 0)
				stall_left <= idle_gap();
		end
	end

	// Scoreboard: on each item transaction queue its characters, on each
	// result transaction check against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item.valid && item.ready) begin
				if (item_row >= 0 && directed_rows[item_row].digits.len() != 0)
					item_digits = directed_rows[item_row].digits;
				else
					item_digits = radix_digits(item.value, item.command);
				for (int k = 0; k < item_digits.len(); k++)
					awaited_chars.push_back(char_beat_t'{
						character: item_digits.getc(k),
						last:      (k == item_digits.len() - 1)});
				items_taken++;
				if (item.value == '0)
					zero_items++;
				if (item.command > CMD_HEX_UP)
					spare_cmd_items++;
			end
			if (result.valid && result.ready) begin
				chars_seen++;
				if (awaited_chars.size() == 0) begin
					$display("%0t: unexpected character %h with last %b, none owed",
						$time, result.character, result.last);
					failures++;
				end else begin
					want = awaited_chars.pop_front();
					if (result.character !== want.character) begin
						$display("%0t: character mismatch, expected %h got %h",
							$time, want.character, result.character);
						failures++;
					end
					if (result.last !== want.last) begin
						$display("%0t: last flag mismatch, expected %b got %b",
							$time, want.last, result.last);
						failures++;
					end
				end
			end
		end
	end

	// Watchdog: count cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: watchdog expired, %0d characters still owed",
						$time, awaited_chars.size());
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		item.valid      = 1'b0;
		item.value      = '0;
		item.command    = CMD_BIN;
		item_row        = -1;
		result.ready    = 1'b0;
		stall_left      = 0;
		cycle_count     = '0;
		failures        = 0;
		items_taken     = 0;
		chars_seen      = 0;
		zero_items      = 0;
		spare_cmd_items = 0;
		quiet_cycles    = 0;

		// Hold reset low, then release it on a clock edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_number(directed_rows[i].value, directed_rows[i].command, i, 1'b0);
		wait_for_drain();

		// Random numbers; every fourth block of forty goes back to back, and
		// halfway through the sender holds off until the block has emptied.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				wait_for_drain();
			send_number(random_value(), random_command(), -1, ((n / 40) % 4) == 3);
		end
		wait_for_drain();

		// Let any stray character show itself before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d numbers (%0d from the table) into %0d characters.",
			items_taken, NUM_DIRECTED, chars_seen);
		$display("Zero values: %0d, unused base commands: %0d, mismatches: %0d.",
			zero_items, spare_cmd_items, failures);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/ura_pkg.sv
hw/rtl/ura_if.sv
hw/rtl/ura_dabble.sv
hw/rtl/unsigned_radix_to_ascii_unit.sv
verif/unsigned_radix_to_ascii_unit_tb.sv
